### design/tbm_pkg.sv
package tbm_pkg;

    // Field widths of the reading, the summary and the accumulators.
    localparam int READ_W    = 16;
    localparam int VAL_W     = 15;
    localparam int CNT_W     = 8;
    localparam int IDX_W     = 7;
    localparam int SUM_W     = 23;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = $clog2(SUM_W);
    localparam int NUM_CAT   = 4;

    // Reset values of the limit registers, in sixteenths of a degree.
    localparam logic [VAL_W-1:0] NORMAL_DEFAULT   = 15'd464;
    localparam logic [VAL_W-1:0] WARNING_DEFAULT  = 15'd704;
    localparam logic [VAL_W-1:0] CRITICAL_DEFAULT = 15'd944;
    localparam logic [VAL_W-1:0] ALARM_DEFAULT    = 15'd720;
    localparam logic [VAL_W-1:0] MIN_START        = 15'h7FFF;

    // Last step of the one-bit-per-cycle mean divider.
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL,
        REG_WARNING,
        REG_CRITICAL,
        REG_ALARM
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CAT_NORMAL,
        CAT_WARNING,
        CAT_CRITICAL,
        CAT_SHUTDOWN
    } t_cat;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;
        logic div_load;
        logic div_step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

### design/tbm_ctrl.sv
module tbm_ctrl
    import tbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_batch_end,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               accept;

    assign accept = i_valid && (r_state == ST_ACCUM);

    // Next state and divider step count.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_ACCUM: begin
                if (accept && i_batch_end) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_step  = '0;
                n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    // Commands for the current state.
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                o_ready      = 1'b1;
                o_cmd.acc_en = i_valid;
            end
            ST_LOAD:   o_cmd.div_load = 1'b1;
            ST_DIVIDE: o_cmd.div_step = 1'b1;
            ST_EMIT:   o_cmd.emit     = i_status.out_free;
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTHESIS
    // A batch-ending transfer always starts the mean calculation.
    a_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_batch_end) |=> (r_state == ST_LOAD))
        else $error("batch end did not start the divider");

    // The summary is only written when the output register can take it.
    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("summary emitted into an occupied output register");

    // The divider takes one step for each bit of the sum before the summary state.
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> ##(SUM_W + 1) (r_state == ST_EMIT))
        else $error("divider ran for the wrong number of steps");
`endif

endmodule

### design/tbm_dpath.sv
module tbm_dpath
    import tbm_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic signed [READ_W-1:0] i_reading,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [VAL_W-1:0]      i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_alarm_found,
    output logic [IDX_W-1:0]      o_alarm_index,
    output logic [VAL_W-1:0]      o_alarm_value,
    output logic [CNT_W-1:0]      o_fault_count,
    output logic [CNT_W-1:0]      o_good_count,
    output logic [VAL_W-1:0]      o_lowest,
    output logic [VAL_W-1:0]      o_highest,
    output logic [VAL_W-1:0]      o_mean,
    output logic [CNT_W-1:0]      o_normal_total,
    output logic [CNT_W-1:0]      o_warning_total,
    output logic [CNT_W-1:0]      o_critical_total,
    output logic [CNT_W-1:0]      o_shutdown_total
);

    localparam int POS_W = $clog2(CAPACITY + 1);

    // Limit registers.
    logic [VAL_W-1:0] r_normal_lim, r_warning_lim, r_critical_lim, r_alarm_lim;

    // Batch accumulators.
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_faults, n_faults;
    logic [CNT_W-1:0] r_goods, n_goods;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [VAL_W-1:0] r_min, n_min;
    logic [VAL_W-1:0] r_max, n_max;
    logic [CNT_W-1:0] r_cat [NUM_CAT];
    logic [CNT_W-1:0] n_cat [NUM_CAT];
    logic             r_seen, n_seen;
    logic [IDX_W-1:0] r_first_pos, n_first_pos;
    logic [VAL_W-1:0] r_first_val, n_first_val;

    // Divider: remainder and the dividend shifting into the quotient.
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0] r_quo, n_quo;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   divisor;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    logic             negative;
    logic [VAL_W-1:0] rd_val;
    logic             in_range;
    logic [7:0]       pos_ext;
    t_cat             cat;

    assign negative = i_reading[READ_W-1];
    assign rd_val   = i_reading[VAL_W-1:0];
    assign in_range = (r_pos < POS_W'(CAPACITY));
    assign pos_ext  = 8'(r_pos);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_status.out_free = out_free;

    // Category of the current reading; earlier limits take precedence.
    always_comb begin
        priority if (rd_val <= r_normal_lim) begin
            cat = CAT_NORMAL;
        end else if (rd_val <= r_warning_lim) begin
            cat = CAT_WARNING;
        end else if (rd_val <= r_critical_lim) begin
            cat = CAT_CRITICAL;
        end else begin
            cat = CAT_SHUTDOWN;
        end
    end

    // Accumulator update on an accepted reading, clear on summary.
    always_comb begin
        n_pos       = r_pos;
        n_faults    = r_faults;
        n_goods     = r_goods;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_cat       = r_cat;
        n_seen      = r_seen;
        n_first_pos = r_first_pos;
        n_first_val = r_first_val;
        if (i_cmd.emit) begin
            n_pos       = '0;
            n_faults    = '0;
            n_goods     = '0;
            n_sum       = '0;
            n_min       = MIN_START;
            n_max       = '0;
            n_seen      = 1'b0;
            n_first_pos = '0;
            n_first_val = '0;
            for (int i = 0; i < NUM_CAT; i++) begin
                n_cat[i] = '0;
            end
        end else if (i_cmd.acc_en && in_range) begin
            n_pos = r_pos + 1'b1;
            if (negative) begin
                n_faults = r_faults + 1'b1;
            end else begin
                if (!r_seen && (rd_val >= r_alarm_lim)) begin
                    n_seen      = 1'b1;
                    n_first_pos = pos_ext[IDX_W-1:0];
                    n_first_val = rd_val;
                end
                n_goods = r_goods + 1'b1;
                n_sum   = r_sum + SUM_W'(rd_val);
                if (rd_val < r_min) begin
                    n_min = rd_val;
                end
                if (rd_val > r_max) begin
                    n_max = rd_val;
                end
                n_cat[cat] = r_cat[cat] + 1'b1;
            end
        end
    end

    // Restoring divider, one quotient bit per step.
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign divisor = {1'b0, r_goods};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_cmd.div_load) begin
            n_rem = '0;
            n_quo = r_sum;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= divisor) begin
                n_rem = CNT_W'(rem_sh - divisor);
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

    // Output valid: set by a summary, cleared by a completed transfer.
    always_comb begin
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Accumulators and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_faults    <= '0;
            r_goods     <= '0;
            r_sum       <= '0;
            r_min       <= MIN_START;
            r_max       <= '0;
            r_seen      <= 1'b0;
            r_first_pos <= '0;
            r_first_val <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CAT; i++) begin
                r_cat[i] <= '0;
            end
        end else begin
            r_pos       <= n_pos;
            r_faults    <= n_faults;
            r_goods     <= n_goods;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_cat       <= n_cat;
            r_seen      <= n_seen;
            r_first_pos <= n_first_pos;
            r_first_val <= n_first_val;
            r_out_valid <= n_out_valid;
        end
    end

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_lim   <= NORMAL_DEFAULT;
            r_warning_lim  <= WARNING_DEFAULT;
            r_critical_lim <= CRITICAL_DEFAULT;
            r_alarm_lim    <= ALARM_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_NORMAL:   r_normal_lim   <= i_cfg_data;
                REG_WARNING:  r_warning_lim  <= i_cfg_data;
                REG_CRITICAL: r_critical_lim <= i_cfg_data;
                REG_ALARM:    r_alarm_lim    <= i_cfg_data;
                default:      r_alarm_lim    <= r_alarm_lim;
            endcase
        end
    end

    // Divider working registers.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // Summary register, loaded when the controller emits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_alarm_found    <= r_seen;
            o_alarm_index    <= r_first_pos;
            o_alarm_value    <= r_first_val;
            o_fault_count    <= r_faults;
            o_good_count     <= r_goods;
            o_lowest         <= (r_goods != '0) ? r_min : '0;
            o_highest        <= r_max;
            o_mean           <= (r_goods != '0) ? r_quo[VAL_W-1:0] : '0;
            o_normal_total   <= r_cat[CAT_NORMAL];
            o_warning_total  <= r_cat[CAT_WARNING];
            o_critical_total <= r_cat[CAT_CRITICAL];
            o_shutdown_total <= r_cat[CAT_SHUTDOWN];
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // Every reading inside capacity is either a fault or a good reading.
    a_pos_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (9'(r_goods) + 9'(r_faults)) == 9'(r_pos))
        else $error("fault and good counts do not add up to the position");

    // Every good reading lands in exactly one category.
    a_cat_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (10'(r_cat[CAT_NORMAL]) + 10'(r_cat[CAT_WARNING]) + 10'(r_cat[CAT_CRITICAL])
            + 10'(r_cat[CAT_SHUTDOWN])) == 10'(r_goods))
        else $error("category totals do not add up to the good count");

    // A summary leaves the batch cleared and the output register full.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && (r_pos == '0) && !r_seen))
        else $error("summary did not clear the batch state");
`endif

endmodule

### design/temperature_batch_monitor.sv
// Temperature batch monitor.
// Readings arrive on the input channel (i_valid, o_ready, i_reading, i_batch_end),
// one transfer per reading; negative readings are counted as sensor faults.
// A reading without i_batch_end goes straight into the accumulators, so such
// readings stream at one per cycle. The batch-ending reading starts the mean
// divider, a restoring unit that produces one quotient bit per cycle over the
// 23-bit sum: o_valid rises and o_ready returns together once the summary is
// written into the output register by the summary state of the sequencer.
// The summary waits in an output register (o_valid, i_ready); a new batch
// is accepted while it waits, but the next summary cannot be written until
// the receiver has taken the previous one, so a stall on the output holds
// the block in its summary state with o_ready low.
// Readings beyond the batch capacity are ignored, except that a batch end
// still produces the summary. Limit registers take i_cfg_we, i_cfg_idx, i_cfg_data;
// the user must write them only while the block is idle, which is not enforced.
// Synchronous active-low reset restores the default limits, clears the
// batch and drops o_valid; there is no clearing pass.
module temperature_batch_monitor
    import tbm_pkg::*;
#(
    parameter int MAX_READINGS = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [READ_W-1:0] i_reading,
    input  logic                     i_batch_end,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [VAL_W-1:0]         i_cfg_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_alarm_found,
    output logic [IDX_W-1:0]         o_alarm_index,
    output logic [VAL_W-1:0]         o_alarm_value,
    output logic [CNT_W-1:0]         o_fault_count,
    output logic [CNT_W-1:0]         o_good_count,
    output logic [VAL_W-1:0]         o_lowest,
    output logic [VAL_W-1:0]         o_highest,
    output logic [VAL_W-1:0]         o_mean,
    output logic [CNT_W-1:0]         o_normal_total,
    output logic [CNT_W-1:0]         o_warning_total,
    output logic [CNT_W-1:0]         o_critical_total,
    output logic [CNT_W-1:0]         o_shutdown_total
);

    // A batch never holds more readings than the output counts can show.
    localparam int CAPACITY = (MAX_READINGS < 128) ? MAX_READINGS : 128;

    t_cmd    cmd;
    t_status status;

    // Sequencer for accumulate, divide and summary.
    tbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_batch_end (i_batch_end),
        .o_ready     (o_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Accumulators, divider, limit registers and summary register.
    tbm_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_reading        (i_reading),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_alarm_found    (o_alarm_found),
        .o_alarm_index    (o_alarm_index),
        .o_alarm_value    (o_alarm_value),
        .o_fault_count    (o_fault_count),
        .o_good_count     (o_good_count),
        .o_lowest         (o_lowest),
        .o_highest        (o_highest),
        .o_mean           (o_mean),
        .o_normal_total   (o_normal_total),
        .o_warning_total  (o_warning_total),
        .o_critical_total (o_critical_total),
        .o_shutdown_total (o_shutdown_total)
    );

endmodule
